### design/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types and constants for the residency capacity evictor.
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam int Entries = 32;

  localparam logic [2:0] OP_NOTE    = 3'd0;
  localparam logic [2:0] OP_ENSURE  = 3'd1;
  localparam logic [2:0] OP_MARK    = 3'd2;
  localparam logic [2:0] OP_PIN     = 3'd3;
  localparam logic [2:0] OP_UNPIN   = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  localparam logic [44:0] USED_MAX = {45{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_SINGLE, S_SCAN, S_CHECK, S_VSCAN, S_EVICT, S_COMMIT, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch request
    logic single;      // apply non-ensure op
    logic scan_clear;  // reset scan index
    logic scan_step;   // one entry of the load scan
    logic vscan_step;  // one entry of the victim search
    logic evict;       // evict chosen victim
    logic commit_step; // one entry of the commit pass
    logic [1:0] status;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_ensure;
    logic scan_last;
    logic cap_zero;
    logic too_big;
    logic over;
    logic have_victim;
  } sts_t;

endpackage

### design/residency_capacity_evictor.sv
// ----------------------------------------------------------------------------
// residency_capacity_evictor
// Tracks 32 tensor entries against a byte budget, evicting by next-use rank.
// ----------------------------------------------------------------------------
// Requests arrive on s_axis (tuser = opcode, tdata = other fields); one
// result per request leaves on m_axis from an output register. capacity_we
// writes the byte budget; the user must write it only while the block is idle,
// and the block does not enforce this. Zero disables eviction.
// Non-ensure requests pass from acceptance through S_SINGLE, where the op is
// applied, to S_DONE, which loads the result register. Ensure runs the load
// scan over all 32 entries, a check, then per eviction a victim search over
// the table, one entry a cycle, the evict and a new check, then the commit
// pass over all entries and S_DONE. One request is in flight at a time; the
// next is taken once the result is registered, and the block waits with a
// finished result while the output register is full and m_axis_tready is
// low. Reset clears the whole table, the budget, byte total and touch
// clock.
// ----------------------------------------------------------------------------
module residency_capacity_evictor (
  input  logic          clk,
  input  logic          rst,
  input  logic          capacity_we,
  input  logic [39:0]   capacity_data,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // entry_index, byte_count, use_rank, home_address, load_mask, protect_mask
  input  logic [191:0]  s_axis_tdata,
  // opcode
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status, resident flag, entry_address, bytes_in_use, evicted_count
  output logic [103:0]  m_axis_tdata
);

  rce_pkg::cmd_t cmd;
  rce_pkg::sts_t sts;
  logic in_ready, out_set, out_free, in_fire;
  logic [101:0] result;

  assign in_fire = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {2'b00, result};

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_set) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  rce_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .sts,
    .in_ready, .out_valid_set(out_set), .cmd
  );

  rce_datapath u_dp (
    .clk, .rst,
    .cfg_we(capacity_we), .cfg_data(capacity_data),
    .req({s_axis_tdata[188:0], s_axis_tuser}),
    .cmd, .sts, .result
  );

endmodule

### design/rce_datapath.sv
// ----------------------------------------------------------------------------
// rce_datapath
// Entry table, byte accounting and one-entry-per-cycle scans.
// ----------------------------------------------------------------------------
module rce_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [39:0]        cfg_data,
  input  logic [191:0]       req,
  input  rce_pkg::cmd_t      cmd,
  output rce_pkg::sts_t      sts,
  output logic [101:0]       result
);

  logic [39:0] capacity;
  logic [2:0]  op;
  logic [4:0]  idx;
  logic [39:0] bytes;
  logic [31:0] rank;
  logic [47:0] addr;
  logic [31:0] lmask, pmask;

  logic [rce_pkg::Entries-1:0] res_f, load_f, pend;
  logic [7:0]  pins   [rce_pkg::Entries];
  logic [39:0] sizes  [rce_pkg::Entries];
  logic [31:0] ranks  [rce_pkg::Entries];
  logic [31:0] stamps [rce_pkg::Entries];
  logic [47:0] addrs  [rce_pkg::Entries];
  logic [44:0] used;
  logic [31:0] tclk;

  logic [5:0]  si;
  logic [4:0]  sidx;
  logic [45:0] need;
  logic [5:0]  evicted;
  logic        have, best_ok;
  logic [4:0]  best;
  logic [31:0] best_rank, best_stamp;

  logic [31:0] tclk1;
  logic [45:0] sum_used;
  logic        elig, better;
  logic [31:0] rb;
  logic [40:0] sz_max;
  logic [45:0] add_sum;

  assign sidx  = si[4:0];
  assign tclk1 = tclk + 32'd1;
  assign sum_used = {1'b0, used} + need;
  assign rb = ranks[sidx] ^ 32'h8000_0000;
  assign elig = res_f[sidx] && !load_f[sidx] && pins[sidx] == 8'd0 && !pmask[sidx];
  assign better = !have || rb > best_rank ||
                  (rb == best_rank && stamps[sidx] < best_stamp);
  assign sz_max = {1'b0, (bytes > sizes[idx]) ? bytes : sizes[idx]};
  assign add_sum = {1'b0, used} + {6'd0, sizes[sidx]};

  assign sts.is_ensure  = op == rce_pkg::OP_ENSURE;
  assign sts.scan_last  = si == 6'(rce_pkg::Entries - 1);
  assign sts.cap_zero   = capacity == 40'd0;
  assign sts.too_big    = need > {6'd0, capacity};
  assign sts.over       = sum_used > {6'd0, capacity};
  assign sts.have_victim = best_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
      res_f <= '0;
      load_f <= '0;
      used <= '0;
      tclk <= '0;
      for (int i = 0; i < rce_pkg::Entries; i++) begin
        pins[i] <= '0;
        sizes[i] <= '0;
        ranks[i] <= '0;
        stamps[i] <= '0;
        addrs[i] <= '0;
      end
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (cmd.take) begin
        {pmask, lmask, addr, rank, bytes, idx, op} <= req;
        evicted <= '0;
      end
      if (cmd.scan_clear) begin
        si <= '0;
        have <= 1'b0;
        best_ok <= 1'b0;
        if (cmd.take) begin
          need <= '0;
          pend <= '0;
        end
      end
      if (cmd.single) begin
        case (op)
          rce_pkg::OP_NOTE: begin
            sizes[idx] <= sz_max[39:0];
            ranks[idx] <= rank;
            stamps[idx] <= tclk1;
            tclk <= tclk1;
          end
          rce_pkg::OP_MARK: begin
            addrs[idx] <= addr;
            sizes[idx] <= sz_max[39:0];
            if (!res_f[idx] && !load_f[idx])
              used <= ({1'b0, used} + {5'd0, sz_max} > {1'b0, rce_pkg::USED_MAX}) ?
                      rce_pkg::USED_MAX : used + {5'd0, sz_max[39:0]};
            res_f[idx] <= 1'b1;
            load_f[idx] <= 1'b0;
            stamps[idx] <= tclk1;
            tclk <= tclk1;
          end
          rce_pkg::OP_PIN: begin
            if (pins[idx] != 8'hff) pins[idx] <= pins[idx] + 8'd1;
            stamps[idx] <= tclk1;
            tclk <= tclk1;
          end
          rce_pkg::OP_UNPIN: begin
            if (pins[idx] != 8'd0) begin
              pins[idx] <= pins[idx] - 8'd1;
              stamps[idx] <= tclk1;
              tclk <= tclk1;
            end
          end
          rce_pkg::OP_RELEASE: begin
            pins[idx] <= '0;
            stamps[idx] <= tclk1;
            tclk <= tclk1;
          end
          default: ;
        endcase
      end
      if (cmd.scan_step) begin
        si <= si + 6'd1;
        if (lmask[sidx]) begin
          stamps[sidx] <= tclk1;
          tclk <= tclk1;
          if (!res_f[sidx] && !load_f[sidx]) begin
            pend[sidx] <= 1'b1;
            need <= need + {6'd0, sizes[sidx]};
          end
        end
      end
      if (cmd.vscan_step) begin
        si <= si + 6'd1;
        if (elig && better) begin
          have <= 1'b1;
          best_ok <= 1'b1;
          best <= sidx;
          best_rank <= rb;
          best_stamp <= stamps[sidx];
        end
      end
      if (cmd.evict) begin
        res_f[best] <= 1'b0;
        used <= (used >= {5'd0, sizes[best]}) ? used - {5'd0, sizes[best]} : '0;
        if (evicted != 6'd63) evicted <= evicted + 6'd1;
      end
      if (cmd.commit_step) begin
        si <= si + 6'd1;
        if (pend[sidx] && !load_f[sidx] && !res_f[sidx]) begin
          load_f[sidx] <= 1'b1;
          used <= (add_sum > {1'b0, rce_pkg::USED_MAX}) ? rce_pkg::USED_MAX : add_sum[44:0];
        end
      end
      if (cmd.out_load) begin
        result[1:0]    <= cmd.status;
        result[2]      <= res_f[idx];
        result[50:3]   <= addrs[idx];
        result[95:51]  <= used;
        result[101:96] <= sts.is_ensure ? evicted : 6'd0;
      end
    end
  end

endmodule

### design/rce_ctrl.sv
// ----------------------------------------------------------------------------
// rce_ctrl
// Sequencer for single-entry ops and the ensure scan / evict / commit loop.
// ----------------------------------------------------------------------------
module rce_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_free,
  input  rce_pkg::sts_t  sts,
  output logic           in_ready,
  output logic           out_valid_set,
  output rce_pkg::cmd_t  cmd
);

  rce_pkg::state_t state, state_next;
  logic [1:0] status, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rce_pkg::S_IDLE;
      status <= rce_pkg::ST_OK;
    end else begin
      state <= state_next;
      status <= status_next;
    end
  end

  always_comb begin
    state_next = state;
    status_next = status;
    case (state)
      rce_pkg::S_IDLE: if (in_fire) begin
        state_next = rce_pkg::S_SINGLE;
        status_next = rce_pkg::ST_OK;
      end
      rce_pkg::S_SINGLE: state_next = sts.is_ensure ? rce_pkg::S_SCAN : rce_pkg::S_DONE;
      rce_pkg::S_SCAN: if (sts.scan_last) state_next = rce_pkg::S_CHECK;
      rce_pkg::S_CHECK: begin
        if (sts.cap_zero) state_next = rce_pkg::S_COMMIT;
        else if (sts.too_big) begin
          status_next = rce_pkg::ST_TOO_BIG;
          state_next = rce_pkg::S_DONE;
        end else if (sts.over) state_next = rce_pkg::S_VSCAN;
        else state_next = rce_pkg::S_COMMIT;
      end
      rce_pkg::S_VSCAN: if (sts.scan_last) state_next = rce_pkg::S_EVICT;
      rce_pkg::S_EVICT: begin
        if (!sts.have_victim) begin
          status_next = rce_pkg::ST_BLOCKED;
          state_next = rce_pkg::S_DONE;
        end else state_next = rce_pkg::S_CHECK;
      end
      rce_pkg::S_COMMIT: if (sts.scan_last) state_next = rce_pkg::S_DONE;
      rce_pkg::S_DONE: if (out_free) state_next = rce_pkg::S_IDLE;
      default: state_next = rce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = status;
    in_ready = 1'b0;
    out_valid_set = 1'b0;
    case (state)
      rce_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_fire;
        cmd.scan_clear = in_fire;
      end
      rce_pkg::S_SINGLE: cmd.single = !sts.is_ensure;
      rce_pkg::S_SCAN: cmd.scan_step = 1'b1;
      rce_pkg::S_CHECK: cmd.scan_clear = 1'b1;
      rce_pkg::S_VSCAN: cmd.vscan_step = 1'b1;
      rce_pkg::S_EVICT: cmd.evict = sts.have_victim;
      rce_pkg::S_COMMIT: cmd.commit_step = 1'b1;
      rce_pkg::S_DONE: begin
        cmd.out_load = out_free;
        out_valid_set = out_free;
      end
      default: ;
    endcase
  end

endmodule
